/* hw/rtl/raw10bl_pkg.sv */
`timescale 1ns / 1ps

package raw10bl_pkg;

    // Sizes of the line-width register, one pixel, one packed group and the widest line
    localparam int unsigned LineWidthW     = 14;
    localparam int unsigned PixW           = 10;
    localparam int unsigned GroupW         = 40;
    localparam int unsigned MaxLineWidth   = 8192;

    localparam logic [LineWidthW-1:0] LineWidthReset = 14'd3280;
    localparam logic [PixW-1:0]       PixMax         = 10'd1023;

    // Pass selected by req_type
    localparam logic ReqMeasure = 1'b0;
    localparam logic ReqCorrect = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [GroupW-1:0] packed_group;
        logic              frame_start;
    } raw10bl_in_t;

    typedef struct packed {
        logic [PixW-1:0] pixel_0;
        logic [PixW-1:0] pixel_1;
        logic [PixW-1:0] pixel_2;
        logic [PixW-1:0] pixel_3;
    } raw10bl_out_t;

    // Control for the item that moves from the input to the result register
    typedef struct packed {
        logic advance;
        logic frame_start;
        logic measure;
    } raw10bl_step_t;

endpackage

/* hw/rtl/raw10bl_position.sv */
`timescale 1ns / 1ps

module raw10bl_position
    import raw10bl_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH = MaxLineWidth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [LineWidthW-1:0] line_width,
    input  raw10bl_step_t         step,
    output logic                  row_odd
);

    localparam int unsigned CapRaw = (MAX_LINE_WIDTH / 4) * 4;
    localparam int unsigned Cap    = (CapRaw < 4) ? 4 : CapRaw;
    localparam int unsigned ColW   = $clog2(Cap + 1);
    localparam int unsigned EW     = (ColW > LineWidthW) ? ColW : LineWidthW;
    localparam int unsigned SW     = EW + 1;

    logic [ColW-1:0] column_reg;
    logic [ColW-1:0] column_next;
    logic            row_odd_reg;
    logic            row_odd_next;
    logic [EW-1:0]   lw_masked;
    logic [EW-1:0]   eff_width;
    logic [ColW-1:0] col_base;
    logic [SW-1:0]   col_sum;
    logic            row_base;
    logic            wrap;

    // Clamp the configured width to a multiple of four within range
    always_comb begin
        lw_masked = EW'({line_width[LineWidthW-1:2], 2'b00});
        if (lw_masked > EW'(Cap)) begin
            eff_width = EW'(Cap);
        end else if (lw_masked < EW'(4)) begin
            eff_width = EW'(4);
        end else begin
            eff_width = lw_masked;
        end
    end

    // Advance by one group (from column 0, even row on a frame start), wrap at the line end and toggle the row parity
    always_comb begin
        col_base     = step.frame_start ? '0 : column_reg;
        row_base     = step.frame_start ? 1'b0 : row_odd_reg;
        col_sum      = SW'(col_base) + SW'(4);
        wrap         = (col_sum >= SW'(eff_width));
        column_next  = wrap ? '0 : col_sum[ColW-1:0];
        row_odd_next = row_base ^ wrap;
    end

    assign row_odd = row_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            row_odd_reg <= 1'b0;
        end else if (step.advance) begin
            column_reg  <= column_next;
            row_odd_reg <= row_odd_next;
        end
    end

    a_col_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg[1:0] == 2'b00)
        else $error("column not group aligned");

    a_fs_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step.advance && step.frame_start |=> (column_reg == ColW'(4)) || (column_reg == '0))
        else $error("frame start did not restart the column");

    a_row_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step.advance && !step.frame_start && !wrap |=> row_odd_reg == $past(row_odd_reg))
        else $error("row parity changed inside a line");

endmodule

/* hw/rtl/raw10bl_pixel.sv */
`timescale 1ns / 1ps

module raw10bl_pixel
    import raw10bl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  raw10bl_step_t     step,
    input  logic              row_odd,
    input  logic [GroupW-1:0] group,
    output raw10bl_out_t      result
);

    logic [PixW-1:0] min_blue_reg;
    logic [PixW-1:0] min_green_reg;
    logic [PixW-1:0] min_red_reg;
    logic [PixW-1:0] min_blue_next;
    logic [PixW-1:0] min_green_next;
    logic [PixW-1:0] min_red_next;
    logic [PixW-1:0] base_blue;
    logic [PixW-1:0] base_green;
    logic [PixW-1:0] base_red;
    logic [PixW-1:0] min_even;
    logic [PixW-1:0] min_odd;
    logic [PixW-1:0] pix [4];
    logic [PixW-1:0] res [4];

    function automatic logic [PixW-1:0] min3(input logic [PixW-1:0] a,
                                             input logic [PixW-1:0] b,
                                             input logic [PixW-1:0] c);
        logic [PixW-1:0] m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    function automatic logic [PixW-1:0] sat_sub(input logic [PixW-1:0] a,
                                                input logic [PixW-1:0] m);
        return (a > m) ? (a - m) : '0;
    endfunction

    // Unpack: high eight bits from bytes 0..3, low two bits from byte 4
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pix[k] = {group[8*k +: 8], group[32 + 2*k +: 2]};
        end
    end

    // Minima seen by this group; a measure frame start restarts them
    always_comb begin
        if (step.frame_start && step.measure) begin
            base_blue  = PixMax;
            base_green = PixMax;
            base_red   = PixMax;
        end else begin
            base_blue  = min_blue_reg;
            base_green = min_green_reg;
            base_red   = min_red_reg;
        end
    end

    // Fold the group into the minima: BGGR, even rows B G, odd rows G R
    always_comb begin
        min_blue_next  = base_blue;
        min_green_next = base_green;
        min_red_next   = base_red;
        if (!row_odd) begin
            min_blue_next  = min3(base_blue, pix[0], pix[2]);
            min_green_next = min3(base_green, pix[1], pix[3]);
        end else begin
            min_green_next = min3(base_green, pix[0], pix[2]);
            min_red_next   = min3(base_red, pix[1], pix[3]);
        end
    end

    // Subtract the colour minimum in the correct pass, pass raw otherwise
    always_comb begin
        min_even = row_odd ? base_green : base_blue;
        min_odd  = row_odd ? base_red : base_green;
        for (int k = 0; k < 4; k++) begin
            if (step.measure) begin
                res[k] = pix[k];
            end else begin
                res[k] = sat_sub(pix[k], (k % 2 == 0) ? min_even : min_odd);
            end
        end
        result.pixel_0 = res[0];
        result.pixel_1 = res[1];
        result.pixel_2 = res[2];
        result.pixel_3 = res[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_blue_reg  <= PixMax;
            min_green_reg <= PixMax;
            min_red_reg   <= PixMax;
        end else if (step.advance && step.measure) begin
            min_blue_reg  <= min_blue_next;
            min_green_reg <= min_green_next;
            min_red_reg   <= min_red_next;
        end
    end

    a_min_nonincr: assert property (@(posedge aclk) disable iff (!aresetn)
        step.advance && !step.frame_start |=>
            (min_blue_reg <= $past(min_blue_reg)) && (min_green_reg <= $past(min_green_reg))
            && (min_red_reg <= $past(min_red_reg)))
        else $error("minimum grew without a frame start");

    a_correct_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        step.advance && !step.measure |=>
            $stable(min_blue_reg) && $stable(min_green_reg) && $stable(min_red_reg))
        else $error("correct pass changed a minimum");

    a_measure_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        step.measure |-> (result.pixel_0 == pix[0]) && (result.pixel_3 == pix[3]))
        else $error("measure pass altered a pixel");

endmodule

/* hw/rtl/raw10_bayer_black_level_core.sv */
`timescale 1ns / 1ps
// A beat accepted into the input register moves on to the result register and m_data
// (the unpack and min/subtract sit between the two registers).
// Throughput: one beat per cycle, set by the single pass through that logic;
// s_ready drops only when both registers hold beats and m_ready is low.
// Reset (aresetn, synchronous, active low): empty pipeline, line_width 3280,
// minima 1023, column 0, even row.

module raw10_bayer_black_level_core
    import raw10bl_pkg::*;
#(
    parameter int unsigned MAX_LINE_WIDTH = MaxLineWidth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  raw10bl_in_t           s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output raw10bl_out_t          m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LineWidthW-1:0] cfg_data
);

    logic [LineWidthW-1:0] line_width_reg;
    logic                  in_valid_reg;
    raw10bl_in_t           in_data_reg;
    logic                  out_valid_reg;
    raw10bl_out_t          out_data_reg;
    raw10bl_out_t          result;
    raw10bl_step_t         step;
    logic                  row_odd;
    logic                  advance;

    // Move the held beat on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        step.advance     = advance;
        step.frame_start = in_data_reg.frame_start;
        step.measure     = (in_data_reg.req_type == ReqMeasure);
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LineWidthReset;
        end else if (cfg_valid && cfg_ready) begin
            line_width_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    raw10bl_position #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .line_width(line_width_reg),
        .step      (step),
        .row_odd   (row_odd)
    );

    raw10bl_pixel u_pixel (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .row_odd(row_odd),
        .group  (in_data_reg.packed_group),
        .result (result)
    );

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced beat missing from result register");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("held beat lost or changed");

endmodule

/* tb/tb_raw10_bayer_black_level_core.sv */
`timescale 1ns / 1ps

module tb_raw10_bayer_black_level_core;
    import raw10bl_pkg::*;

    localparam int unsigned QuietLimit = 2000;
    localparam int unsigned NumPhases  = 12;

    typedef enum int {
        ClrBlue  = 0,
        ClrGreen = 1,
        ClrRed   = 2
    } bayer_colour_e;

    // Tracks line position and per-colour black level, predicts pixel beats
    class black_level_tracker;
        logic [LineWidthW-1:0] line_width;
        logic [PixW-1:0]       black_lvl [3];
        int unsigned           column;
        bit                    row_odd;
        raw10bl_out_t          expected_pixels [$];
        int unsigned           error_count;
        int unsigned           groups_seen;
        int unsigned           frames_seen;
        int unsigned           correct_groups;
        int unsigned           results_checked;

        function new();
            line_width = LineWidthReset;
            foreach (black_lvl[i]) black_lvl[i] = PixMax;
            column = 0;
            row_odd = 1'b0;
            error_count = 0;
            groups_seen = 0;
            frames_seen = 0;
            correct_groups = 0;
            results_checked = 0;
        endfunction

        function void set_width(logic [LineWidthW-1:0] w);
            line_width = w;
        endfunction

        // Ignore the two low bits, clamp to [4, cap]
        function int unsigned eff_width();
            int unsigned w;
            int unsigned cap;
            w = int'(line_width) & ~32'd3;
            cap = MaxLineWidth & ~32'd3;
            if (cap < 4) cap = 4;
            if (w > cap) w = cap;
            if (w < 4) w = 4;
            return w;
        endfunction

        // BGGR: even row B G B G, odd row G R G R
        function bayer_colour_e colour_at(int k);
            if (!row_odd) return (k % 2) ? ClrGreen : ClrBlue;
            return (k % 2) ? ClrRed : ClrGreen;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function void note_group(raw10bl_in_t g);
            logic [PixW-1:0] pix;
            logic [PixW-1:0] outp [4];
            bayer_colour_e   c;
            groups_seen++;
            // frame start: rewind position, and restart minima when measuring
            if (g.frame_start) begin
                frames_seen++;
                column = 0;
                row_odd = 1'b0;
                if (g.req_type == ReqMeasure) begin
                    foreach (black_lvl[i]) black_lvl[i] = PixMax;
                end
            end
            if (g.req_type == ReqCorrect) correct_groups++;
            for (int k = 0; k < 4; k++) begin
                pix = {g.packed_group[8*k +: 8], g.packed_group[32 + 2*k +: 2]};
                c = colour_at(k);
                if (g.req_type == ReqMeasure) begin
                    if (pix < black_lvl[c]) black_lvl[c] = pix;
                    outp[k] = pix;
                end else begin
                    outp[k] = (pix > black_lvl[c]) ? pix - black_lvl[c] : '0;
                end
            end
            expected_pixels.push_back({outp[0], outp[1], outp[2], outp[3]});
            // advance position, wrap at or past the row end
            column += 4;
            if (column >= eff_width()) begin
                column = 0;
                row_odd = ~row_odd;
            end
        endfunction

        function void check_pixels(raw10bl_out_t got);
            raw10bl_out_t    want;
            logic [PixW-1:0] w4 [4];
            logic [PixW-1:0] g4 [4];
            if (expected_pixels.size() == 0) begin
                $error("pixel beat arrived with no group pending");
                error_count++;
                return;
            end
            want = expected_pixels.pop_front();
            results_checked++;
            {w4[0], w4[1], w4[2], w4[3]} = want;
            {g4[0], g4[1], g4[2], g4[3]} = got;
            for (int k = 0; k < 4; k++) begin
                if (g4[k] !== w4[k]) begin
                    $error("pixel_%0d: expected %0d, actual %0d", k, w4[k], g4[k]);
                    error_count++;
                end
            end
        endfunction

        function void report_leftover();
            if (expected_pixels.size() != 0) begin
                $error("%0d pixel beats never arrived", expected_pixels.size());
                error_count += expected_pixels.size();
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    raw10bl_in_t           s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    raw10bl_out_t          m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [LineWidthW-1:0] cfg_data;

    black_level_tracker tracker = new();
    bit          idling_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned widths_written = 0;

    raw10_bayer_black_level_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Observe every handshake at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                tracker.set_width(cfg_data);
                widths_written++;
            end
            if (s_valid && s_ready) tracker.note_group(s_data);
            if (m_valid && m_ready) tracker.check_pixels(m_data);
        end
    end

    // Count cycles without any beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QuietLimit) @(posedge aclk);
        $error("no beat moved for %0d cycles", QuietLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hold off the result side in random bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [GroupW-1:0] random_group(bit dark);
        logic [GroupW-1:0] g;
        g[31:0] = $urandom;
        g[39:32] = 8'($urandom_range(0, 255));
        // keep the high bytes near black so minima move
        if (dark) begin
            for (int k = 0; k < 4; k++) g[8*k +: 8] = 8'($urandom_range(0, 15));
        end
        return g;
    endfunction

    // Offer one group, hold until accepted; starts and ends on a falling edge
    task automatic send_group(input logic req, input logic [GroupW-1:0] grp, input logic fs);
        raw10bl_in_t item;
        int unsigned gap;
        item.req_type = req;
        item.packed_group = grp;
        item.frame_start = fs;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    // Drop valid and wait for every pending pixel beat to drain
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_line_width(input logic [LineWidthW-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Frames alternate measure then correct; some noise in pass and frame start
    task automatic run_frames(input int unsigned n, input bit one_frame);
        int unsigned left;
        int unsigned frame_len;
        logic        frame_req;
        logic        req;
        logic        fs;
        bit          dark_frame;
        bit          measure_next;
        left = n;
        measure_next = 1'b1;
        while (left != 0) begin
            frame_len = one_frame ? left : $urandom_range(1, 3 * tracker.eff_width() / 4);
            if (frame_len > left) frame_len = left;
            frame_req = measure_next ? ReqMeasure : ReqCorrect;
            if ($urandom_range(0, 7) == 0) frame_req = 1'($urandom_range(0, 1));
            measure_next = (frame_req == ReqCorrect);
            dark_frame = $urandom_range(0, 1);
            for (int i = 0; i < frame_len; i++) begin
                fs = (i == 0) || (!one_frame && $urandom_range(0, 31) == 0);
                req = ($urandom_range(0, 15) == 0) ? ~frame_req : frame_req;
                send_group(req, random_group(dark_frame && $urandom_range(0, 3) != 0), fs);
            end
            left -= frame_len;
        end
    endtask

    initial begin
        int unsigned phase_width [NumPhases];
        int unsigned phase_items [NumPhases];
        phase_width = '{8, 12, 0, 7, 3280, 10, 16383, 8192, 4, 20, 6, 24};
        phase_items = '{60, 60, 40, 40, 100, 60, 250, 40, 60, 60, 40, 60};

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // correct pass before any measure, then value extremes at reset width
        send_group(ReqCorrect, 40'hFF_FFFF_FFFF, 1'b0);
        send_group(ReqCorrect, random_group(1'b0), 1'b1);
        send_group(ReqMeasure, 40'h00_0000_0000, 1'b1);
        send_group(ReqMeasure, 40'hFF_FFFF_FFFF, 1'b0);
        send_group(ReqCorrect, 40'hFF_FFFF_FFFF, 1'b0);
        send_group(ReqMeasure, 40'hFF_FFFF_FFFF, 1'b1);
        send_group(ReqCorrect, 40'h00_0000_0000, 1'b0);

        // narrowest row: every group flips the row, so all colours show up
        settle_pipeline();
        write_line_width(14'd4);
        send_group(ReqMeasure, 40'hE4_4030_2010, 1'b1);
        send_group(ReqMeasure, 40'h1B_8070_6050, 1'b0);
        send_group(ReqMeasure, 40'h55_5555_5555, 1'b0);
        send_group(ReqMeasure, 40'hAA_AAAA_AAAA, 1'b0);
        send_group(ReqCorrect, 40'hE4_4030_2010, 1'b1);
        send_group(ReqCorrect, 40'h1B_8070_6050, 1'b0);
        send_group(ReqCorrect, 40'hFF_FFFF_FFFF, 1'b0);
        send_group(ReqCorrect, 40'hFF_FFFF_FFFF, 1'b1);
        send_group(ReqMeasure, random_group(1'b1), 1'b0);
        send_group(ReqMeasure, random_group(1'b1), 1'b1);
        send_group(ReqCorrect, random_group(1'b0), 1'b0);

        // random frames over a range of widths; a width change may land mid-row
        for (int p = 0; p < NumPhases; p++) begin
            settle_pipeline();
            write_line_width(LineWidthW'(phase_width[p]));
            idling_on = (phase_width[p] == 16383) ? 1'b0 : ($urandom_range(0, 3) != 0);
            run_frames(phase_items[p], phase_width[p] == 16383);
        end

        // last stretch runs at full rate
        settle_pipeline();
        idling_on = 1'b0;
        write_line_width(LineWidthW'(4 * $urandom_range(1, 16)));
        run_frames(100, 1'b0);
        settle_pipeline();
        repeat (4) @(negedge aclk);
        tracker.report_leftover();

        $display("Sent %0d groups in %0d frames, %0d of them in the correct pass.",
                 tracker.groups_seen, tracker.frames_seen, tracker.correct_groups);
        $display("Checked %0d pixel beats across %0d line-width settings.",
                 tracker.results_checked, widths_written);
        if (tracker.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* raw10_bayer_black_level_core.f */
hw/rtl/raw10bl_pkg.sv
hw/rtl/raw10bl_position.sv
hw/rtl/raw10bl_pixel.sv
hw/rtl/raw10_bayer_black_level_core.sv
tb/tb_raw10_bayer_black_level_core.sv
